>>> hdl/dsn_pkg.sv
// Shared constants, codes and state type for the difference-set necklace search unit.
package dsn_pkg;

  localparam int unsigned DefMaxMarks  = 20;
  localparam int unsigned DefMaxPoints = 128;

  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned DensW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 8;
  localparam int unsigned NeedW   = 11;

  localparam logic [StatusW-1:0] STATUS_FOUND   = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NONE    = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_CFG = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_NUM_POINTS  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DENSITY     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRUNE_LEVEL = 2'd2;

  localparam logic [1:0] PHASE_PERIODIC = 2'd0;
  localparam logic [1:0] PHASE_LYNDON   = 2'd1;
  localparam logic [1:0] PHASE_DECR     = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_P0B,
    S_P2,
    S_ENDIFF,
    S_ENCHK,
    S_EMIT,
    S_SINGLE
  } state_e;

endpackage

>>> hdl/dsn_if.sv
// Handshake channels for start items and result items.
interface dsn_start_if;
  logic valid;
  logic ready;
  logic start_req;
  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

interface dsn_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] position;
  logic [1:0] status;
  logic       last;
  modport source (output valid, output position, output status, output last, input ready);
  modport sink (input valid, input position, input status, input last, output ready);
endinterface

>>> hdl/difference_set_necklace_search_unit.sv
// Sequenced backtracking search for planar difference sets over fixed-density necklaces.
//
//  channel   direction  contents
//  start_i   in         start_req
//  result_o  out        position, status, last
//  cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i
//
// One item runs the whole search; the start channel is not ready until it ends.
// Each entry to a level runs every earlier mark through the difference unit and then
// the check, and each branch step goes through the single mark read port.
// Results leave through an output register; a stall there holds the search at its end.
// Reset clears the sequencer and the output valid; the stacks are written before use.
module difference_set_necklace_search_unit #(
  parameter int unsigned MAX_MARKS  = dsn_pkg::DefMaxMarks,
  parameter int unsigned MAX_POINTS = dsn_pkg::DefMaxPoints
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dsn_start_if.sink                   start_i,
  dsn_result_if.source                result_o,
  input  logic                        cfg_we_i,
  input  logic [dsn_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [dsn_pkg::CfgDatW-1:0] cfg_data_i
);
  import dsn_pkg::*;

  localparam int unsigned Depth   = MAX_MARKS + 1;
  localparam int unsigned LvlW    = $clog2(Depth);
  localparam int unsigned MapBits = MAX_POINTS / 2;
  localparam int unsigned KIdxW   = $clog2(MapBits);
  localparam int unsigned CntW    = $clog2(MapBits + 1);

  state_e state_q, state_d;

  logic [PosW-1:0]    n_q;
  logic [DensW-1:0]   d_q;
  logic [DensW-1:0]   pl_q;

  logic [PosW-1:0]    mark_mem [Depth];
  logic               lyn_mem  [Depth];
  logic [LvlW-1:0]    per_mem  [Depth];
  logic [1:0]         ph_mem   [Depth];
  logic [MapBits-1:0] map_mem  [Depth];
  logic [CntW-1:0]    cnt_mem  [Depth];

  logic [LvlW-1:0]    t_q, t_d, lvl_q, lvl_d, i_q, i_d, e_q, e_d;
  logic [PosW-1:0]    j0_q, j0_d, tmp_q, tmp_d, cur_q, cur_d;
  logic               tlyn_q, tlyn_d;
  logic [MapBits-1:0] mapw_q, mapw_d;
  logic [CntW-1:0]    cntw_q, cntw_d;
  logic signed [NeedW-1:0] base_q, base_d;
  logic [StatusW-1:0] stat_q, stat_d;

  logic               ov_q, ov_d;
  logic [PosW-1:0]    opos_q, opos_d;
  logic [StatusW-1:0] ostat_q, ostat_d;
  logic               olast_q, olast_d;

  logic               mark_we, lyn_we, lyn_wd, per_we, ph_we, map_we;
  logic [LvlW-1:0]    mark_wa, per_wa, per_wd, ph_wa;
  logic [PosW-1:0]    mark_wd;
  logic [1:0]         ph_wd;

  logic [LvlW-1:0]    ra, t1, cur_p;
  logic [1:0]         cur_ph;
  logic [PosW-1:0]    rd_mark;
  logic               out_free, accept;
  logic [2*DensW-1:0] dd;
  logic [8:0]         tail, mx, diff9, r9, nr9, k9;
  logic [PosW-1:0]    jj;
  logic [PosW+DensW-1:0] jprod;
  logic [2*LvlW:0]    tri_sum;
  logic signed [NeedW-1:0] need, cnt_s;
  logic               launch;
  logic [LvlW-1:0]    launch_lvl;
  logic [PosW-1:0]    launch_mark;

  assign t1       = t_q + LvlW'(1);
  assign cur_p    = per_mem[t_q];
  assign cur_ph   = ph_mem[t_q];
  assign out_free = !ov_q || result_o.ready;
  assign accept   = start_i.valid && start_i.ready;
  assign start_i.ready = (state_q == S_IDLE);

  assign result_o.valid    = ov_q;
  assign result_o.position = opos_q;
  assign result_o.status   = ostat_q;
  assign result_o.last     = olast_q;

  assign dd    = DensW'(d_q) * DensW'(d_q - DensW'(1));
  assign tail  = 9'(n_q) - 9'(d_q) + 9'(t1);
  assign mx    = 9'(tmp_q) + 9'(rd_mark);
  assign jj    = j0_q - PosW'(1);
  assign jprod = jj * d_q;
  assign tri_sum = (2*LvlW+1)'((lvl_q * (lvl_q + LvlW'(1))) >> 1);
  assign need  = base_q + NeedW'(signed'({1'b0, tri_sum}));
  assign cnt_s = NeedW'(signed'({1'b0, cntw_q}));

  assign diff9 = 9'(cur_q) - 9'(rd_mark);
  assign r9    = (diff9 >= 9'(n_q)) ? diff9 - 9'(n_q) : diff9;
  assign nr9   = 9'(n_q) - r9;
  assign k9    = (r9 <= nr9) ? r9 : nr9;

  always_comb begin
    unique case (state_q)
      S_STEP:  ra = (cur_ph == PHASE_PERIODIC) ? t1 - cur_p : t1;
      S_P0B:   ra = cur_p;
      S_P2:    ra = t_q;
      S_ENDIFF: ra = i_q;
      S_EMIT:  ra = e_q;
      default: ra = '0;
    endcase
    rd_mark = (ra == '0) ? '0 : mark_mem[ra];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && start_i.start_req) begin
          if (d_q < DensW'(2) || 32'(d_q) > MAX_MARKS || 32'(n_q) > MAX_POINTS
              || 11'(n_q) > 11'(dd) + 11'd1 || n_q < PosW'(d_q)) begin
            state_d = S_SINGLE;
          end else begin
            state_d = S_STEP;
          end
        end
      end
      S_STEP: begin
        if (t_q == '0) begin
          state_d = (jprod < (PosW+DensW)'(n_q)) ? S_SINGLE : S_ENDIFF;
        end else begin
          unique case (cur_ph)
            PHASE_PERIODIC: state_d = S_P0B;
            PHASE_LYNDON:   state_d = lyn_mem[t1] ? S_STEP : S_ENDIFF;
            default:        state_d = S_P2;
          endcase
        end
      end
      S_P0B:    state_d = (mx <= tail) ? S_ENDIFF : S_STEP;
      S_P2:     state_d = (9'(tmp_q) <= 9'(rd_mark) + 9'd1) ? S_STEP : S_ENDIFF;
      S_ENDIFF: state_d = (i_q == lvl_q - LvlW'(1)) ? S_ENCHK : S_ENDIFF;
      S_ENCHK: begin
        if (5'(lvl_q) >= pl_q && cnt_s < need) begin
          state_d = S_STEP;
        end else if (6'(lvl_q) + 6'd1 >= 6'(d_q)) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_STEP;
        end
      end
      S_EMIT:   if (out_free && 6'(e_q) == 6'(d_q)) state_d = S_IDLE;
      S_SINGLE: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    t_d = t_q; lvl_d = lvl_q; i_d = i_q; e_d = e_q;
    j0_d = j0_q; tmp_d = tmp_q; tlyn_d = tlyn_q; cur_d = cur_q;
    mapw_d = mapw_q; cntw_d = cntw_q; base_d = base_q; stat_d = stat_q;
    ov_d = ov_q && !result_o.ready;
    opos_d = opos_q; ostat_d = ostat_q; olast_d = olast_q;
    mark_we = 1'b0; mark_wa = t1; mark_wd = '0;
    lyn_we = 1'b0; lyn_wd = 1'b1;
    per_we = 1'b0; per_wa = t1; per_wd = t1;
    ph_we = 1'b0; ph_wa = t_q; ph_wd = PHASE_DECR;
    map_we = 1'b0;
    launch = 1'b0; launch_lvl = t1; launch_mark = rd_mark;
    unique case (state_q)
      S_IDLE: begin
        t_d = '0;
        j0_d = n_q - PosW'(d_q) + PosW'(2);
        base_d = NeedW'(signed'({1'b0, n_q >> 1})) - NeedW'(signed'({1'b0, dd >> 1}));
        stat_d = (n_q < PosW'(d_q) && !(d_q < DensW'(2) || 32'(d_q) > MAX_MARKS))
                 ? STATUS_NONE : STATUS_BAD_CFG;
        if (!(d_q < DensW'(2) || 32'(d_q) > MAX_MARKS || 32'(n_q) > MAX_POINTS
              || 11'(n_q) > 11'(dd) + 11'd1)) begin
          stat_d = STATUS_NONE;
        end
      end
      S_STEP: begin
        if (t_q == '0) begin
          stat_d = STATUS_NONE;
          if (!(jprod < (PosW+DensW)'(n_q))) begin
            j0_d = jj;
            mark_we = 1'b1; mark_wd = jj;
            lyn_we = 1'b1;
            per_we = 1'b1; per_wd = LvlW'(1);
            launch = 1'b1; launch_mark = jj;
          end
        end else begin
          unique case (cur_ph)
            PHASE_PERIODIC: begin
              tmp_d = rd_mark;
              tlyn_d = lyn_mem[t1 - cur_p];
            end
            PHASE_LYNDON: begin
              ph_we = 1'b1;
              if (!lyn_mem[t1]) begin
                lyn_we = 1'b1;
                per_we = 1'b1;
                launch = 1'b1;
              end
            end
            default: tmp_d = rd_mark;
          endcase
        end
      end
      S_P0B: begin
        ph_we = 1'b1;
        mark_we = 1'b1;
        if (mx <= tail) begin
          mark_wd = PosW'(mx);
          lyn_we = 1'b1; lyn_wd = tlyn_q;
          ph_wd = PHASE_LYNDON;
          per_we = 1'b1; per_wd = cur_p;
          launch = 1'b1; launch_mark = PosW'(mx);
        end else begin
          mark_wd = PosW'(tail + 9'd1);
        end
      end
      S_P2: begin
        if (9'(tmp_q) <= 9'(rd_mark) + 9'd1) begin
          t_d = t_q - LvlW'(1);
        end else begin
          mark_we = 1'b1; mark_wd = tmp_q - PosW'(1);
          lyn_we = 1'b1;
          per_we = 1'b1;
          launch = 1'b1; launch_mark = tmp_q - PosW'(1);
        end
      end
      S_ENDIFF: begin
        i_d = i_q + LvlW'(1);
        if (k9 != 9'd0 && 32'(k9) <= MapBits && !mapw_q[KIdxW'(k9 - 9'd1)]) begin
          mapw_d[KIdxW'(k9 - 9'd1)] = 1'b1;
          cntw_d = cntw_q + CntW'(1);
        end
      end
      S_ENCHK: begin
        map_we = 1'b1;
        e_d = LvlW'(1);
        if (!(5'(lvl_q) >= pl_q && cnt_s < need)
            && !(6'(lvl_q) + 6'd1 >= 6'(d_q))) begin
          ph_we = 1'b1; ph_wa = lvl_q; ph_wd = PHASE_PERIODIC;
          t_d = lvl_q;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_d = 1'b1;
          opos_d = (6'(e_q) == 6'(d_q)) ? n_q : rd_mark;
          ostat_d = STATUS_FOUND;
          olast_d = (6'(e_q) == 6'(d_q));
          e_d = e_q + LvlW'(1);
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          ov_d = 1'b1;
          opos_d = '0;
          ostat_d = stat_q;
          olast_d = 1'b1;
        end
      end
      default: ;
    endcase
    if (launch) begin
      lvl_d = launch_lvl;
      cur_d = launch_mark;
      i_d = '0;
      mapw_d = (t_q == '0) ? '0 : map_mem[t_q];
      cntw_d = (t_q == '0) ? '0 : cnt_mem[t_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q <= PosW'(7);
      d_q <= DensW'(3);
      pl_q <= '0;
      t_q <= '0;
      e_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      t_q <= t_d;
      e_q <= e_d;
      ov_q <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_NUM_POINTS:  n_q <= cfg_data_i;
          CFG_DENSITY:     d_q <= cfg_data_i[DensW-1:0];
          CFG_PRUNE_LEVEL: pl_q <= cfg_data_i[DensW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d; i_q <= i_d; j0_q <= j0_d; tmp_q <= tmp_d; tlyn_q <= tlyn_d;
    cur_q <= cur_d; mapw_q <= mapw_d; cntw_q <= cntw_d; base_q <= base_d;
    stat_q <= stat_d; opos_q <= opos_d; ostat_q <= ostat_d; olast_q <= olast_d;
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (lyn_we) lyn_mem[mark_wa] <= lyn_wd;
    if (per_we) per_mem[per_wa] <= per_wd;
    if (ph_we) ph_mem[ph_wa] <= ph_wd;
    if (map_we) begin
      map_mem[lvl_q] <= mapw_q;
      cnt_mem[lvl_q] <= cntw_q;
    end
  end

endmodule

>>> verif/difference_set_necklace_search_checker.sv
// Checker that mirrors the difference-set search and compares every result item.
module difference_set_necklace_search_checker
  import dsn_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_valid_i,
  input  logic               start_ready_i,
  input  logic               start_req_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [PosW-1:0]    res_position_i,
  input  logic [StatusW-1:0] res_status_i,
  input  logic               res_last_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PosW-1:0]    position;
    logic [StatusW-1:0] status;
    logic               last;
  } mark_result_t;

  mark_result_t expected_marks[$];

  logic [7:0] cyc_len;
  logic [4:0] marks_wanted;
  logic [4:0] prune_from;

  int           mark_at[0:20];
  bit           lyndon_at[0:20];
  int           period_at[0:20];
  int           phase_at[0:20];
  logic [127:0] diffs_at[0:20];

  assign pending_o = expected_marks.size();

  // Returns 0 when the branch is cut, 1 to descend and 2 when the set is complete.
  function automatic int open_level(input int t, input int p);
    int n, d, r, k, need;
    n = int'(cyc_len);
    d = int'(marks_wanted);
    period_at[t] = p;
    diffs_at[t] = diffs_at[t-1];
    for (int i = 0; i < t && n > 0; i++) begin
      r = (mark_at[t] - mark_at[i]) % n;
      if (r < 0) r += n;
      k = (r <= n - r) ? r : n - r;
      if (k >= 1 && k <= 128) diffs_at[t][k-1] = 1'b1;
    end
    if (t >= int'(prune_from)) begin
      need = n / 2 - d * (d - 1) / 2 + t * (t + 1) / 2;
      if ($countones(diffs_at[t]) < need) return 0;
    end
    if (t + 1 >= d) return 2;
    phase_at[t] = 0;
    return 1;
  endfunction

  function automatic void push_single(input logic [StatusW-1:0] st);
    mark_result_t e;
    e.position = '0;
    e.status = st;
    e.last = 1'b1;
    expected_marks.push_back(e);
  endfunction

  function automatic void search_marks();
    int n, d, lo, hi, r, t, t1, p, j, tail, mx, depth;
    mark_result_t e;
    n = int'(cyc_len);
    d = int'(marks_wanted);
    if (d < 2 || d > 20 || n > 128 || n > d * (d - 1) + 1) begin
      push_single(STATUS_BAD_CFG);
      return;
    end
    lo = (n - 1) / d + 1;
    hi = n - d + 1;
    mark_at[0] = 0;
    mark_at[d] = n;
    lyndon_at[0] = 1'b0;
    diffs_at[0] = '0;
    mark_at[1] = hi + 1;
    depth = 0;
    forever begin
      t = depth;
      t1 = t + 1;
      if (t == 0) begin
        j = mark_at[1] - 1;
        if (j < lo) begin
          push_single(STATUS_NONE);
          return;
        end
        mark_at[1] = j;
        lyndon_at[1] = 1'b1;
        r = open_level(1, 1);
      end else begin
        p = period_at[t];
        if (phase_at[t] == 0) begin
          tail = n - d + t1;
          mx = mark_at[t1-p] + mark_at[p];
          if (mx <= tail) begin
            mark_at[t1] = mx;
            lyndon_at[t1] = lyndon_at[t1-p];
            phase_at[t] = 1;
            r = open_level(t1, p);
          end else begin
            mark_at[t1] = tail + 1;
            phase_at[t] = 2;
            continue;
          end
        end else if (phase_at[t] == 1) begin
          phase_at[t] = 2;
          if (lyndon_at[t1]) continue;
          lyndon_at[t1] = 1'b1;
          r = open_level(t1, t1);
        end else begin
          j = mark_at[t1] - 1;
          if (j < mark_at[t] + 1) begin
            depth = t - 1;
            continue;
          end
          mark_at[t1] = j;
          lyndon_at[t1] = 1'b1;
          r = open_level(t1, t1);
        end
      end
      if (r == 2) break;
      if (r == 1) depth = t1;
    end
    for (int m = 1; m <= d; m++) begin
      e.position = mark_at[m][7:0];
      e.status = STATUS_FOUND;
      e.last = (m == d);
      expected_marks.push_back(e);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mark_result_t e;
    if (!rst_ni) begin
      cyc_len <= 8'd7;
      marks_wanted <= 5'd3;
      prune_from <= 5'd0;
      expected_marks.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_NUM_POINTS:  cyc_len <= cfg_data_i;
          CFG_DENSITY:     marks_wanted <= cfg_data_i[4:0];
          CFG_PRUNE_LEVEL: prune_from <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (start_valid_i && start_ready_i && start_req_i) search_marks();
      if (res_valid_i && res_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (expected_marks.size() == 0) begin
          if (fail_count_o < 10)
            $display("unexpected result: position %0d status %0d last %0d",
                     res_position_i, res_status_i, res_last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_marks.pop_front();
          if (e.position !== res_position_i || e.status !== res_status_i ||
              e.last !== res_last_i) begin
            if (fail_count_o < 10)
              $display("mismatch: expected pos %0d st %0d last %0d, got pos %0d st %0d last %0d",
                       e.position, e.status, e.last,
                       res_position_i, res_status_i, res_last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

>>> verif/difference_set_necklace_search_unit_tb.sv
// Top of the testbench: clock, reset, stimulus, result back-pressure and verdict.
module difference_set_necklace_search_unit_tb;
  import dsn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 6000000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDatW-1:0] cfg_data_i;
  int                 fail_count;
  int                 pending;
  int                 result_count;
  int                 cycles;
  int                 starts_sent;
  int                 cfg_sets;
  bit                 calm;

  dsn_start_if  start_ch();
  dsn_result_if result_ch();

  difference_set_necklace_search_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_ch),
    .result_o   (result_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  difference_set_necklace_search_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_valid_i  (start_ch.valid),
    .start_ready_i  (start_ch.ready),
    .start_req_i    (start_ch.start_req),
    .res_valid_i    (result_ch.valid),
    .res_ready_i    (result_ch.ready),
    .res_position_i (result_ch.position),
    .res_status_i   (result_ch.status),
    .res_last_i     (result_ch.last),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[difference_set_necklace_search_unit] ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // The receiver stalls a drawn number of cycles before each result item.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_config(input int n, input int d, input int prune);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_NUM_POINTS;
    cfg_data_i <= n[7:0];
    @(posedge clk_i);
    cfg_idx_i <= CFG_DENSITY;
    cfg_data_i <= d[7:0];
    @(posedge clk_i);
    cfg_idx_i <= CFG_PRUNE_LEVEL;
    cfg_data_i <= prune[7:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_sets++;
  endtask

  task automatic send_start(input bit req, input bit hold);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_ch.valid <= 1'b1;
    start_ch.start_req <= req;
    do @(posedge clk_i); while (!start_ch.ready);
    if (!hold) start_ch.valid <= 1'b0;
    if (req) starts_sent++;
  endtask

  initial begin
    int n, d, prune;
    bit change;
    start_ch.valid = 1'b0;
    start_ch.start_req = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NUM_POINTS;
    cfg_data_i = '0;
    cycles = 0;
    starts_sent = 0;
    cfg_sets = 0;
    calm = 1'b1;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed part: reset settings, an ignored item, bad and empty settings and extremes.
    send_start(1'b0, 1'b0);
    send_start(1'b1, 1'b0);
    calm = 1'b0;
    set_config(13, 4, 0);   send_start(1'b1, 1'b0);
    set_config(3, 2, 0);    send_start(1'b1, 1'b0);
    set_config(4, 2, 20);   send_start(1'b1, 1'b0);
    set_config(128, 2, 0);  send_start(1'b1, 1'b0);
    set_config(3, 20, 0);   send_start(1'b1, 1'b0);
    set_config(21, 20, 31); send_start(1'b1, 1'b0);
    set_config(8, 0, 0);    send_start(1'b1, 1'b0);
    set_config(8, 1, 0);    send_start(1'b1, 1'b0);
    set_config(8, 31, 0);   send_start(1'b1, 1'b0);
    set_config(200, 20, 0); send_start(1'b1, 1'b0);
    set_config(255, 31, 31); send_start(1'b1, 1'b0);
    set_config(0, 2, 0);    send_start(1'b1, 1'b0);
    set_config(11, 4, 0);   send_start(1'b1, 1'b0);
    set_config(21, 5, 0);   send_start(1'b1, 1'b0);
    set_config(31, 6, 0);   send_start(1'b1, 1'b0);
    set_config(31, 6, 5);   send_start(1'b1, 1'b0);
    set_config(16, 6, 3);   send_start(1'b1, 1'b0);
    set_config(128, 5, 1);  send_start(1'b1, 1'b0);

    // Random part: mostly small searchable settings, some invalid, some ignored items.
    for (int i = 0; i < 80; i++) begin
      calm = ($urandom_range(0, 4) == 0);
      change = ($urandom_range(0, 2) == 0);
      if (change) begin
        n = $urandom_range(3, 21);
        d = $urandom_range(2, 7);
        prune = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
        if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 31);
        if ($urandom_range(0, 12) == 0) n = $urandom_range(129, 255);
        set_config(n, d, prune);
      end
      send_start($urandom_range(0, 7) != 0, 1'b0);
    end
    start_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d searches over %0d register settings, checking %0d result items.",
             starts_sent, cfg_sets, result_count);
    if (fail_count == 0) begin
      $display("[difference_set_necklace_search_unit] OK");
    end else begin
      $display("%0d result items failed.", fail_count);
      $display("[difference_set_necklace_search_unit] ERROR");
    end
    $finish;
  end

endmodule
